// ===== src/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastFill  = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finish;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FINAL,
    S_PAD,
    S_PADLEN,
    S_OUT
  } eng_state_e;

  typedef enum logic [1:0] {
    K_DATA,
    K_PAD1,
    K_LAST
  } blk_kind_e;

  typedef struct packed {
    logic    valid;
    sha_in_t item;
  } q_head_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(logic [31:0] v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== src/sha_queue.sv =====
// Front end: accepts input transfers, drops empty items, queues the rest.
module sha_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sha_pkg::sha_in_t in_data_i,
  output sha_pkg::q_head_t head_o,
  input  logic             pop_i
);
  import sha_pkg::*;

  sha_in_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign in_stall_o   = (cnt_q == QCntW'(QDepth));
  assign push         = in_valid_i && !in_stall_o && (in_data_i.has_byte || in_data_i.finish);
  assign pop          = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== src/sha_engine.sv =====
// Back end: block buffer, padding, 64-round compression and digest output.
module sha_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::q_head_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sha_pkg::sha_out_t out_data_o
);
  import sha_pkg::*;

  eng_state_e  state_q, state_d;
  blk_kind_e   kind_q;
  logic [5:0]  round_q, fill_q;
  logic [60:0] cnt_q;
  logic        fin_q;
  logic [2:0]  idx_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] r_q [8];
  logic [63:0] bits;
  logic [31:0] w_new, t1, t2;
  logic        out_xfer;
  sha_in_t     item;

  assign item     = head_i.item;
  assign bits     = {cnt_q, 3'b000};
  assign out_xfer = out_valid_o && !out_stall_i;
  assign w_new    = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
  assign t1       = r_q[7] + bsig1(r_q[4]) + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]))
                  + RoundK[round_q] + w_q[0];
  assign t2       = bsig0(r_q[0]) + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          if (item.has_byte && fill_q == LastFill) state_d = S_ROUND;
          else if (item.finish)                    state_d = S_PAD;
        end
      end
      S_ROUND: if (round_q == LastRound) state_d = S_FINAL;
      S_FINAL: begin
        case (kind_q)
          K_DATA:  state_d = fin_q ? S_PAD : S_IDLE;
          K_PAD1:  state_d = S_PADLEN;
          K_LAST:  state_d = S_OUT;
          default: state_d = S_IDLE;
        endcase
      end
      S_PAD:    state_d = S_ROUND;
      S_PADLEN: state_d = S_ROUND;
      S_OUT:    if (out_xfer && idx_q == LastWord) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == S_IDLE) && head_i.valid;
    out_valid_o = (state_q == S_OUT);
    out_data_o.digest_word = h_q[idx_q];
    out_data_o.word_index  = idx_q;
    out_data_o.last_word   = (idx_q == LastWord);
  end

  // Block words and working variables carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q != S_ROUND && state_d == S_ROUND) begin
      for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
    end else if (state_q == S_ROUND) begin
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end

    case (state_q)
      S_IDLE: begin
        if (pop_o && item.has_byte)
          w_q[fill_q[5:2]][8*(3 - fill_q[1:0]) +: 8] <= item.data_byte;
      end
      S_ROUND: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_new;
      end
      S_PAD: begin
        for (int j = 0; j < 16; j++) begin
          if (4'(j) > fill_q[5:2]) begin
            w_q[j] <= '0;
          end else if (4'(j) == fill_q[5:2]) begin
            for (int l = 0; l < 4; l++) begin
              if (2'(l) == fill_q[1:0])     w_q[j][8*(3-l) +: 8] <= PadByte;
              else if (2'(l) > fill_q[1:0]) w_q[j][8*(3-l) +: 8] <= '0;
            end
          end
        end
        if (fill_q < LenOffset) begin
          w_q[14] <= bits[63:32];
          w_q[15] <= bits[31:0];
        end
      end
      S_PADLEN: begin
        for (int j = 0; j < 14; j++) w_q[j] <= '0;
        w_q[14] <= bits[63:32];
        w_q[15] <= bits[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_DATA;
      round_q <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      state_q <= state_d;
      if (state_q != S_ROUND && state_d == S_ROUND) round_q <= '0;
      else if (state_q == S_ROUND)                  round_q <= round_q + 1'b1;
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            fin_q  <= item.finish;
            kind_q <= K_DATA;
            if (item.has_byte) begin
              fill_q <= fill_q + 1'b1;
              cnt_q  <= cnt_q + 1'b1;
            end
          end
        end
        S_FINAL: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
          fin_q <= 1'b0;
        end
        S_PAD: begin
          kind_q <= (fill_q < LenOffset) ? K_LAST : K_PAD1;
          fill_q <= '0;
        end
        S_PADLEN: kind_q <= K_LAST;
        S_OUT: begin
          if (out_xfer) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == LastWord) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
              cnt_q  <= '0;
              fill_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_round_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && round_q == LastRound) |=> (state_q == S_FINAL))
    else $error("round counter did not end compression");
  a_round_stay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && round_q != LastRound) |=> (state_q == S_ROUND))
    else $error("compression left early");
  a_digest_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_data_o.last_word) |=>
      (state_q == S_IDLE && fill_q == '0 && cnt_q == '0 && idx_q == '0))
    else $error("state not restored after digest");

endmodule

// ===== src/sha256_stream_hasher.sv =====
// Top level of the streaming SHA-256 hasher.
//
// Input channel: one transfer carries an optional message byte (has_byte)
// and an optional finish request. Items with neither flag are dropped.
// A two-entry queue buffers items ahead of the hashing engine.
// The idle engine pops each byte from the queue into the block buffer; the
// 64th byte of a block starts the compression: 64 rounds at one per cycle,
// then a fold of the result into the hash words. While a block is
// compressed, the engine takes no further bytes from the queue.
// On finish the engine pads the block and compresses once or, with more
// than 55 bytes pending, twice; then it presents eight digest words,
// word 0 first, last_word on word 7, one per cycle when the receiver does
// not stall. A stall holds the current word. While the engine is busy,
// in_stall_o rises once the queue is full.
// After the last word the hash state returns to its initial values.
// Reset clears the queue and restores the initial hash state at once.
module sha256_stream_hasher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sha_pkg::sha_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sha_pkg::sha_out_t out_data_o
);
  import sha_pkg::*;

  q_head_t head;
  logic    pop;

  sha_queue u_queue (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .head_o (head),
    .pop_i  (pop)
  );

  sha_engine u_engine (
    .clk_i,
    .rst_ni,
    .head_i (head),
    .pop_o  (pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the streaming SHA-256 hasher.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sha_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sha_out_t out_data_o;

  sha256_stream_hasher DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [31:0] hash_st [8];
  logic [7:0] blk_st [64];
  int unsigned fill_st;
  logic [60:0] len_st;

  sha_in_t pending_items[$];
  sha_out_t digest_words[$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  bit quiet = 1'b0;
  bit hold_send = 1'b0;
  bit drain_done = 1'b0;

  function automatic logic [31:0] rr(logic [31:0] v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic hasher_reset();
    for (int i = 0; i < 8; i++) hash_st[i] = InitH[i];
    for (int i = 0; i < 64; i++) blk_st[i] = '0;
    fill_st = 0;
    len_st = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2, x, y;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_st[4*i], blk_st[4*i+1], blk_st[4*i+2], blk_st[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (rr(x, 7) ^ rr(x, 18) ^ (x >> 3)) + w[i-7]
           + (rr(y, 17) ^ rr(y, 19) ^ (y >> 10));
    end
    for (int i = 0; i < 8; i++) r[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (rr(r[4], 6) ^ rr(r[4], 11) ^ rr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundK[i] + w[i];
      t2 = (rr(r[0], 2) ^ rr(r[0], 13) ^ rr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += r[i];
  endtask

  task automatic absorb_item(sha_in_t it);
    logic [63:0] bits;
    sha_out_t o;
    if (it.has_byte) begin
      blk_st[fill_st] = it.data_byte;
      fill_st++;
      len_st = len_st + 1'b1;
      if (fill_st == 64) begin
        compress_block();
        fill_st = 0;
      end
    end
    if (!it.finish) return;
    bits = {len_st, 3'b000};
    blk_st[fill_st] = PadByte;
    fill_st++;
    if (fill_st > 56) begin
      for (int i = fill_st; i < 64; i++) blk_st[i] = '0;
      compress_block();
      fill_st = 0;
    end
    for (int i = fill_st; i < 56; i++) blk_st[i] = '0;
    for (int i = 0; i < 8; i++) blk_st[63-i] = bits[8*i +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = hash_st[i];
      o.word_index = i[2:0];
      o.last_word = (i == 7);
      digest_words.push_back(o);
    end
    hasher_reset();
  endtask

  function automatic sha_in_t mk(logic [7:0] b, logic h, logic f);
    sha_in_t it;
    it.data_byte = b;
    it.has_byte = h;
    it.finish = f;
    return it;
  endfunction

  // driver: hold the payload while stalled
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        absorb_item(in_data_i);
        void'(pending_items.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_items.size() > (in_valid_i && !in_stall_o ? 0 : 0) && !hold_send
            && (quiet || $urandom_range(99) >= 8)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_items[0];
        end else begin
          in_valid_i <= 1'b0;
          in_data_i <= mk(8'($urandom), 1'($urandom), 1'($urandom));
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sha_out_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (digest_words.size() == 0) begin
          $error("unexpected digest word %h", out_data_o.digest_word);
          errors++;
        end else begin
          exp_w = digest_words.pop_front();
          if (out_data_o.digest_word !== exp_w.digest_word) begin
            $error("digest_word exp %h got %h", exp_w.digest_word, out_data_o.digest_word);
            errors++;
          end
          if (out_data_o.word_index !== exp_w.word_index) begin
            $error("word_index exp %0d got %0d", exp_w.word_index, out_data_o.word_index);
            errors++;
          end
          if (out_data_o.last_word !== exp_w.last_word) begin
            $error("last_word exp %0b got %0b", exp_w.last_word, out_data_o.last_word);
            errors++;
          end
        end
      end
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_message(int unsigned n, bit mixed);
    for (int i = 0; i < n; i++) begin
      if (mixed && $urandom_range(9) == 0)
        pending_items.push_back(mk(8'($urandom), 1'b0, 1'b0));
      pending_items.push_back(mk(8'($urandom), 1'b1, (i == n - 1) && $urandom_range(1)));
    end
    if (pending_items.size() == 0 || !pending_items[$].finish)
      pending_items.push_back(mk(8'($urandom), 1'b0, 1'b1));
  endtask

  initial begin
    int unsigned sizes [3];
    hasher_reset();
    sizes[0] = 55;
    sizes[1] = 56;
    sizes[2] = 64;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // empty message, byte with finish, extremes, idle items
    pending_items.push_back(mk(8'hff, 1'b0, 1'b1));
    pending_items.push_back(mk(8'h00, 1'b1, 1'b1));
    pending_items.push_back(mk(8'h5a, 1'b0, 1'b0));
    pending_items.push_back(mk(8'hff, 1'b1, 1'b1));
    pending_items.push_back(mk(8'h61, 1'b1, 1'b0));
    pending_items.push_back(mk(8'h62, 1'b1, 1'b0));
    pending_items.push_back(mk(8'h63, 1'b1, 1'b1));
    pending_items.push_back(mk(8'h00, 1'b0, 1'b0));
    pending_items.push_back(mk(8'h00, 1'b0, 1'b1));
    wait (pending_items.size() == 0);
    // hold off until all digests are out
    hold_send = 1'b1;
    wait (digest_words.size() == 0);
    @(posedge clk_i);
    hold_send = 1'b0;
    // padding boundaries: 55 and 56 bytes, then a full block finished on its last byte
    foreach (sizes[k]) begin
      for (int i = 0; i < sizes[k]; i++)
        pending_items.push_back(mk(8'($urandom), 1'b1, (k == 2) && (i == sizes[k] - 1)));
      if (k != 2) pending_items.push_back(mk(8'h00, 1'b0, 1'b1));
    end
    wait (pending_items.size() == 0);
    quiet = 1'b1;
    push_message(32, 1'b0);
    wait (pending_items.size() == 0);
    quiet = 1'b0;
    for (int m = 0; m < 3; m++) push_message($urandom_range(0, 6), 1'b1);
    wait (pending_items.size() == 0);
    wait (digest_words.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && digest_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
